// ===== rtl/scd_pkg.sv =====
// Package for the sidechain ducking compressor: states, register indexes, constants, tables.
`default_nettype none
package scd_pkg;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOG, ST_DB, ST_TGT, ST_SMA, ST_SMB,
		ST_MK, ST_EXPQ, ST_EXPI, ST_SC1, ST_SC2, ST_DONE
	} state_t;

	localparam logic [2:0] CFG_THRESHOLD = 3'd0;
	localparam logic [2:0] CFG_INV_RATIO = 3'd1;
	localparam logic [2:0] CFG_ATTACK    = 3'd2;
	localparam logic [2:0] CFG_RELEASE   = 3'd3;
	localparam logic [2:0] CFG_MAKEUP    = 3'd4;
	localparam logic [2:0] CFG_STEREO    = 3'd5;

	localparam int MUL_W = 24;
	localparam logic [23:0] DB_PER_LOG2 = 24'd394566;
	localparam logic [23:0] LOG2_PER_DB = 24'd2786635;
	localparam logic [19:0] LOG2_FULL   = 20'd983040;
	localparam logic signed [16:0] LEVEL_FLOOR = 17'sd30720;

	typedef logic [64:0][17:0] rom_t;

	// log2(1+k/64) in Q16 by repeated squaring in Q30
	function automatic rom_t build_log2_rom();
		rom_t rom;
		logic [63:0] y;
		logic [17:0] res;
		rom = '0;
		for (int k = 0; k < 64; k++) begin
			y = 64'(64 + k) << 24;
			res = '0;
			for (int b = 15; b >= 0; b--) begin
				y = (y * y) >> 30;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					res[b] = 1'b1;
				end
			end
			rom[k] = res;
		end
		rom[64] = 18'd65536;
		return rom;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++)
			if (b > v) b = b >> 2;
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(k/64) in Q16 from 2^(1/64) in Q30
	function automatic rom_t build_exp2_rom();
		rom_t rom;
		logic [63:0] q;
		logic [63:0] p;
		q = 64'd2 << 30;
		p = 64'd1 << 30;
		for (int i = 0; i < 6; i++) q = isqrt64(q << 30);
		for (int k = 0; k <= 64; k++) begin
			rom[k] = 18'((p + 64'd8192) >> 14);
			p = (p * q + (64'd1 << 29)) >> 30;
		end
		return rom;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/scd_mul.sv =====
// Shared multiplier with registered product.
`default_nettype none
module scd_mul
	import scd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic [MUL_W-1:0]     a,
	input  wire logic [MUL_W-1:0]     b,
	output logic      [2*MUL_W-1:0]   prod
);

	// register each product
	always_ff @(posedge clk) begin
		prod <= a * b;
	end

endmodule
`default_nettype wire

// ===== rtl/sidechain_ducking_compressor.sv =====
// Top level of the sidechain ducking compressor.
//
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | voice_sample, music_first, music_second,
//         |           |                       | second_present
// out     | output    | out_valid / out_ready | music_first_out, music_second_out,
//         |           |                       | reduction_out
// cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// A new item is taken only after the previous one is through, and after any wait for
// out_ready on the result before it. Each item makes ten passes through the single
// shared 24x24 multiplier, one product per cycle, and then hands the beat to the
// output register.
// in_ready is high only while the sequencer is idle; a result is held in the
// output register until taken. Reset restores the registers and clears the
// smoothed reduction.
`default_nettype none
module sidechain_ducking_compressor
	import scd_pkg::*;
#(
	parameter int MAKEUP_MAX_DB = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [16:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] voice_sample,
	input  wire logic signed [15:0] music_first,
	input  wire logic signed [15:0] music_second,
	input  wire logic               second_present,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      music_first_out,
	output logic signed [15:0]      music_second_out,
	output logic [14:0]             reduction_out
);

	localparam rom_t LOG2_ROM = build_log2_rom();
	localparam rom_t EXP2_ROM = build_exp2_rom();
	localparam logic [MUL_W-1:0] MAKEUP_SCALE = MUL_W'(MAKEUP_MAX_DB * 256);

	state_t state_q, state_d;

	logic signed [15:0] thr_reg_q;
	logic [16:0] ir_reg_q, mf_reg_q;
	logic [15:0] att_q, rel_q;
	logic        stereo_q;

	logic signed [15:0] voice_q, mf1_q, mf2_q;
	logic        sec_q;
	logic [3:0]  e_q;
	logic [17:0] lk_q;
	logic        zero_q, ge_q, gneg_q;
	logic [14:0] target_q, smoothed_q;
	logic [15:0] alpha_q;
	logic [31:0] acc_q;
	logic [17:0] xj_q, m_q;
	logic [5:0]  ipo_q;
	logic [15:0] res1_q;
	logic [15:0] out1_q, out2_q;
	logic [14:0] red_out_q;
	logic        out_valid_q;

	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] prod_q;

	scd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod_q));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_reg_q <= -16'sd5120;
			ir_reg_q  <= 17'd16384;
			att_q     <= 16'd64000;
			rel_q     <= 16'd65400;
			mf_reg_q  <= 17'd0;
			stereo_q  <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_reg_q <= cfg_data[15:0];
				CFG_INV_RATIO: ir_reg_q  <= cfg_data;
				CFG_ATTACK:    att_q     <= cfg_data[15:0];
				CFG_RELEASE:   rel_q     <= cfg_data[15:0];
				CFG_MAKEUP:    mf_reg_q  <= cfg_data;
				CFG_STEREO:    stereo_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp registers at use
	logic signed [16:0] thr_c;
	logic [16:0] ir_c, mf_c, ir_inv;
	always_comb begin
		thr_c = 17'(thr_reg_q);
		if (thr_c > 17'sd0) thr_c = 17'sd0;
		if (thr_c < -LEVEL_FLOOR) thr_c = -LEVEL_FLOOR;
		ir_c = (ir_reg_q > 17'd65536) ? 17'd65536 : ir_reg_q;
		mf_c = (mf_reg_q > 17'd65536) ? 17'd65536 : mf_reg_q;
		ir_inv = 17'd65536 - ir_c;
	end

	// level detector front end: magnitude, exponent, table index
	logic [15:0] a_abs, norm;
	logic [3:0]  e_c;
	logic [5:0]  k_c;
	logic [8:0]  r_c;
	logic [17:0] l_lo, l_hi;
	always_comb begin
		a_abs = voice_q[15] ? 16'(-voice_q) : voice_q;
		e_c = '0;
		for (int i = 0; i < 16; i++)
			if (a_abs[i]) e_c = 4'(i);
		norm = a_abs << (4'd15 - e_c);
		k_c = norm[14:9];
		r_c = norm[8:0];
		l_lo = LOG2_ROM[7'(k_c)];
		l_hi = LOG2_ROM[7'(k_c) + 7'd1];
	end

	// datapath values taken from the product register
	logic [19:0] l2_c, d_c;
	logic [15:0] lvl_mag;
	logic signed [16:0] level_c, g_c;
	logic        ge_c;
	logic [14:0] diff_c, target_c, red_c;
	logic [15:0] alpha_c, g_abs;
	logic [32:0] sum_c;
	logic [13:0] makeup_c;
	logic [20:0] qm_c;
	logic [22:0] u_c;
	logic [5:0]  j_c;
	logic [9:0]  rr_c;
	logic [17:0] x_lo, x_hi, m_c;
	always_comb begin
		l2_c = (20'(e_q) << 16) + 20'(lk_q) + 20'(prod_q >> 9);
		d_c = LOG2_FULL - l2_c;
		lvl_mag = 16'((prod_q + 48'd8388608) >> 24);
		level_c = zero_q ? -LEVEL_FLOOR : -$signed(17'(lvl_mag));
		ge_c = level_c >= thr_c;
		diff_c = 15'(level_c - thr_c);
		target_c = ge_q ? 15'((prod_q + 48'd32768) >> 16) : 15'd0;
		alpha_c = (target_c > smoothed_q) ? att_q : rel_q;
		sum_c = 33'(acc_q) + 33'(prod_q[31:0]) + 33'd32768;
		red_c = 15'(sum_c >> 16);
		makeup_c = 14'((prod_q + 48'd32768) >> 16);
		g_c = $signed(17'(makeup_c)) - $signed(17'(smoothed_q));
		g_abs = g_c[16] ? 16'(-g_c) : 16'(g_c);
		qm_c = 21'((prod_q + 48'd32768) >> 16);
		u_c = gneg_q ? (23'd2097152 - 23'(qm_c)) : (23'd2097152 + 23'(qm_c));
		j_c = u_c[15:10];
		rr_c = u_c[9:0];
		x_lo = EXP2_ROM[7'(j_c)];
		x_hi = EXP2_ROM[7'(j_c) + 7'd1];
		m_c = xj_q + 18'(prod_q >> 10);
	end

	// truncate the scaled magnitude and saturate with the sample's sign
	function automatic logic [15:0] sat16(input logic [47:0] p, input logic [5:0] ipo,
		input logic neg);
		logic [47:0] y;
		y = p >> (6'd48 - ipo);
		if (neg) return (y > 48'd32768) ? 16'h8000 : 16'(-y);
		return (y > 48'd32767) ? 16'h7fff : y[15:0];
	endfunction

	logic [15:0] m1_abs, m2_abs;
	assign m1_abs = mf1_q[15] ? 16'(-mf1_q) : mf1_q;
	assign m2_abs = mf2_q[15] ? 16'(-mf2_q) : mf2_q;

	// sequencer: next state and multiplier operands
	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_LOG;
			ST_LOG: begin
				mul_a = MUL_W'(l_hi - l_lo);
				mul_b = MUL_W'(r_c);
				state_d = ST_DB;
			end
			ST_DB: begin
				mul_a = MUL_W'(d_c);
				mul_b = DB_PER_LOG2;
				state_d = ST_TGT;
			end
			ST_TGT: begin
				mul_a = MUL_W'(diff_c);
				mul_b = MUL_W'(ir_inv);
				state_d = ST_SMA;
			end
			ST_SMA: begin
				mul_a = MUL_W'(alpha_c);
				mul_b = MUL_W'(smoothed_q);
				state_d = ST_SMB;
			end
			ST_SMB: begin
				mul_a = MUL_W'(17'd65536 - 17'(alpha_q));
				mul_b = MUL_W'(target_q);
				state_d = ST_MK;
			end
			ST_MK: begin
				mul_a = MAKEUP_SCALE;
				mul_b = MUL_W'(mf_c);
				state_d = ST_EXPQ;
			end
			ST_EXPQ: begin
				mul_a = MUL_W'(g_abs);
				mul_b = LOG2_PER_DB;
				state_d = ST_EXPI;
			end
			ST_EXPI: begin
				mul_a = MUL_W'(x_hi - x_lo);
				mul_b = MUL_W'(rr_c);
				state_d = ST_SC1;
			end
			ST_SC1: begin
				mul_a = MUL_W'(m1_abs);
				mul_b = MUL_W'(m_c);
				state_d = ST_SC2;
			end
			ST_SC2: begin
				mul_a = MUL_W'(m2_abs);
				mul_b = MUL_W'(m_q);
				state_d = ST_DONE;
			end
			// hold the second product while the previous beat waits
			ST_DONE: begin
				mul_a = MUL_W'(m2_abs);
				mul_b = MUL_W'(m_q);
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	// state register, smoothed reduction and output beat flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			smoothed_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MK) smoothed_q <= red_c;
			if (state_q == ST_DONE && state_d == ST_IDLE) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// working registers, loaded step by step
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				voice_q <= voice_sample;
				mf1_q   <= music_first;
				mf2_q   <= music_second;
				sec_q   <= second_present;
			end
			ST_LOG: begin
				e_q    <= e_c;
				lk_q   <= l_lo;
				zero_q <= (a_abs == 16'd0);
			end
			ST_DB: ;
			ST_TGT: ge_q <= ge_c;
			ST_SMA: begin
				target_q <= target_c;
				alpha_q  <= alpha_c;
			end
			ST_SMB: acc_q <= prod_q[31:0];
			ST_MK: ;
			ST_EXPQ: gneg_q <= g_c[16];
			ST_EXPI: begin
				xj_q  <= x_lo;
				ipo_q <= u_c[21:16];
			end
			ST_SC1: m_q <= m_c;
			ST_SC2: res1_q <= sat16(prod_q, ipo_q, mf1_q[15]);
			// load the output beat once the previous one is gone
			ST_DONE: if (state_d == ST_IDLE) begin
				out1_q    <= res1_q;
				red_out_q <= smoothed_q;
				out2_q    <= (stereo_q && sec_q) ? sat16(prod_q, ipo_q, mf2_q[15]) : mf2_q;
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign music_first_out  = out1_q;
	assign music_second_out = out2_q;
	assign reduction_out    = red_out_q;

	// checks on the sequencer and datapath
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("accepted a beat while busy");
	a_red_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (reduction_out <= 15'd30720))
		else $error("reduction out of range");
	a_state_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_MK) |=> $stable(smoothed_q))
		else $error("smoothed reduction changed outside its step");
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SC2) |-> (ipo_q <= 6'd48))
		else $error("exponent out of range");

endmodule
`default_nettype wire
